@@ rtl/block_bitmap_allocator_assert.svh @@
// assertion macros for the block bitmap allocator
// expects clk and arst_n in the scope of the module that uses them
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define BBA_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define BBA_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
// shared types, codes and helpers for the block bitmap allocator
// no dependencies
`default_nettype none

package bba_pkg;

	// request operation codes
	localparam logic FUNC_MARK = 1'b0;
	localparam logic FUNC_FIND = 1'b1;

	// bitmap byte constants: bit 7 is the lowest block of a byte
	localparam logic [7:0] BIT_LOWEST = 8'h80;
	localparam logic [7:0] BYTE_FULL  = 8'hFF;

	// register file layout
	localparam int CFG_AW = 3;
	localparam logic REG_FIRST_GROUP_BLOCK = 1'b0;
	localparam logic REG_GROUP_COUNT       = 1'b1;
	localparam logic [3:0] GROUP_COUNT_RST = 4'd1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_BELOW = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_NONE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MK_WALK,
		S_MK_MOD,
		S_FIND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] first_group_block;
		logic [3:0]  group_count;
	} cfg_t;

	// position of the first clear bit, most significant bit first
	function automatic logic [2:0] first_zero(input logic [7:0] v);
		logic [2:0] idx;
		logic       hit;
		idx = 3'd0;
		hit = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!hit && !v[i]) begin
				idx = 3'(7 - i);
				hit = 1'b1;
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bba_if.sv @@
// request and response channels of the block bitmap allocator
// no dependencies
`default_nettype none

interface bba_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] block_addr;

	modport source (output valid, output func, output block_addr, input ready);
	modport sink (input valid, input func, input block_addr, output ready);
endinterface

interface bba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] free_block;

	modport source (output valid, output status, output free_block, input ready);
	modport sink (input valid, input status, input free_block, output ready);
endinterface

`default_nettype wire

@@ rtl/bba_cfg.sv @@
// apb register file: base block address and group count
// depends on bba_pkg
`default_nettype none

module bba_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bba_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output bba_pkg::cfg_t                    cfg
);

	bba_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_group_block <= 32'd0;
			cfg_q.group_count       <= bba_pkg::GROUP_COUNT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				bba_pkg::REG_FIRST_GROUP_BLOCK: cfg_q.first_group_block <= pwdata;
				bba_pkg::REG_GROUP_COUNT:       cfg_q.group_count <= pwdata[3:0];
				default:                        cfg_q <= cfg_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			bba_pkg::REG_FIRST_GROUP_BLOCK: prdata = cfg_q.first_group_block;
			bba_pkg::REG_GROUP_COUNT:       prdata = {28'd0, cfg_q.group_count};
			default:                        prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/block_bitmap_allocator.sv @@
// block bitmap allocator: marks blocks used and finds the lowest free block
// mark: walks group by group, then read-modify-writes the byte; below base or out of range fails
// find: scans the live groups from the lowest byte up, one bitmap byte per cycle
// one request in flight; the next is accepted while a result waits in the output register
// reset: async, then a clearing pass zeroes the bitmap ram, during which no request is accepted
`default_nettype none

`include "block_bitmap_allocator_assert.svh"

module block_bitmap_allocator #(
	parameter int GROUP_BITS = 4096,
	parameter int MAX_GROUPS = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bba_pkg::CFG_AW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	bba_req_if.sink                          req,
	bba_rsp_if.source                        rsp
);

	localparam int GROUP_BYTES = (GROUP_BITS + 7) / 8;
	localparam int STORE_BYTES = MAX_GROUPS * GROUP_BYTES;
	localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int BYW = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
	localparam int GW  = $clog2(MAX_GROUPS + 1);
	localparam int TAIL = GROUP_BITS % 8;
	localparam logic [7:0]     TAIL_PAD   = (TAIL == 0) ? 8'h00 : (bba_pkg::BYTE_FULL >> TAIL);
	localparam logic [31:0]    GROUP_SPAN = 32'(GROUP_BITS);
	localparam logic [AW-1:0]  GROUP_STEP = AW'(GROUP_BYTES);
	localparam logic [BYW-1:0] LAST_BYTE  = BYW'(GROUP_BYTES - 1);
	localparam logic [AW-1:0]  LAST_ADDR  = AW'(STORE_BYTES - 1);

	bba_pkg::cfg_t   cfg;
	bba_pkg::state_t state_q, state_d;

	// bitmap ram
	logic [7:0]    mem_q [STORE_BYTES];
	logic [7:0]    rd_data_s1;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata;

	logic [AW-1:0] clr_addr_q;

	// mark walk
	logic [31:0]    mk_offs_q;
	logic [GW-1:0]  mk_grp_q;
	logic [AW-1:0]  mk_gaddr_q;
	logic [AW-1:0]  mk_addr;
	logic [7:0]     mk_mask;
	logic           mk_in_group, mk_out_range, mk_step;

	// find issue side
	logic [AW-1:0]  iss_addr_q;
	logic [BYW-1:0] iss_byte_q;
	logic [GW-1:0]  iss_grp_q;
	logic [31:0]    iss_base_q;
	logic           iss_done_q, iss_last;

	// find check side
	logic           chk_v_s1, chk_final_s1, chk_tail_s1;
	logic [BYW-1:0] chk_byte_s1;
	logic [31:0]    chk_base_s1;
	logic [7:0]     chk_val;
	logic           chk_hit;
	logic [31:0]    found_addr;

	logic [GW-1:0]  live_groups;
	logic           start_mark, start_find;

	// result staging and output register
	logic             res_load, out_load;
	bba_pkg::status_t res_status_d, res_status_q, out_status_q;
	logic [31:0]      res_free_d, res_free_q, out_free_q;
	logic             out_valid_q;

	bba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// group count saturated to the store size
	assign live_groups = (32'(cfg.group_count) > 32'(MAX_GROUPS)) ? GW'(MAX_GROUPS)
		: GW'(cfg.group_count);

	// mark address decode from the remaining offset
	assign mk_addr      = mk_gaddr_q + AW'(BYW'(mk_offs_q >> 3));
	assign mk_mask      = bba_pkg::BIT_LOWEST >> mk_offs_q[2:0];
	assign mk_in_group  = mk_offs_q < GROUP_SPAN;
	assign mk_out_range = mk_grp_q >= live_groups;
	assign mk_step      = (state_q == bba_pkg::S_MK_WALK) && !mk_out_range && !mk_in_group;

	// find scan: last byte of the last live group
	assign iss_last = (iss_byte_q == LAST_BYTE) && ((iss_grp_q + GW'(1)) == live_groups);

	// byte check, padding bits past the group end count as used
	assign chk_val    = rd_data_s1 | (chk_tail_s1 ? TAIL_PAD : 8'h00);
	assign chk_hit    = chk_val != bba_pkg::BYTE_FULL;
	assign found_addr = chk_base_s1 + 32'({chk_byte_s1, bba_pkg::first_zero(chk_val)});

	assign start_mark = req.valid && req.ready && (req.func == bba_pkg::FUNC_MARK);
	assign start_find = req.valid && req.ready && (req.func == bba_pkg::FUNC_FIND);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, ram control and result selection
	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = clr_addr_q;
		mem_wdata    = 8'h00;
		mem_re       = 1'b0;
		mem_raddr    = iss_addr_q;
		res_load     = 1'b0;
		res_status_d = bba_pkg::STAT_OK;
		res_free_d   = 32'd0;
		out_load     = 1'b0;
		unique case (state_q)
			bba_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = bba_pkg::S_IDLE;
				end
			end
			bba_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.func == bba_pkg::FUNC_MARK) begin
						if (req.block_addr < cfg.first_group_block) begin
							res_load     = 1'b1;
							res_status_d = bba_pkg::STAT_BELOW;
							state_d      = bba_pkg::S_DONE;
						end else begin
							state_d = bba_pkg::S_MK_WALK;
						end
					end else if (live_groups == GW'(0)) begin
						res_load     = 1'b1;
						res_status_d = bba_pkg::STAT_NONE;
						state_d      = bba_pkg::S_DONE;
					end else begin
						state_d = bba_pkg::S_FIND;
					end
				end
			end
			bba_pkg::S_MK_WALK: begin
				priority if (mk_out_range) begin
					res_load     = 1'b1;
					res_status_d = bba_pkg::STAT_RANGE;
					state_d      = bba_pkg::S_DONE;
				end else if (mk_in_group) begin
					mem_re    = 1'b1;
					mem_raddr = mk_addr;
					state_d   = bba_pkg::S_MK_MOD;
				end else begin
					state_d = bba_pkg::S_MK_WALK;
				end
			end
			bba_pkg::S_MK_MOD: begin
				mem_we       = 1'b1;
				mem_waddr    = mk_addr;
				mem_wdata    = rd_data_s1 | mk_mask;
				res_load     = 1'b1;
				res_status_d = bba_pkg::STAT_OK;
				state_d      = bba_pkg::S_DONE;
			end
			bba_pkg::S_FIND: begin
				mem_re = !iss_done_q;
				if (chk_v_s1) begin
					if (chk_hit) begin
						res_load     = 1'b1;
						res_status_d = bba_pkg::STAT_OK;
						res_free_d   = found_addr;
						state_d      = bba_pkg::S_DONE;
					end else if (chk_final_s1) begin
						res_load     = 1'b1;
						res_status_d = bba_pkg::STAT_NONE;
						state_d      = bba_pkg::S_DONE;
					end
				end
			end
			bba_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = bba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

	// bitmap ram, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem_q[mem_raddr];
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == bba_pkg::S_CLEAR) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// mark walk: peel off one group per cycle
	always_ff @(posedge clk) begin
		if (start_mark) begin
			mk_offs_q  <= req.block_addr - cfg.first_group_block;
			mk_grp_q   <= '0;
			mk_gaddr_q <= '0;
		end else if (mk_step) begin
			mk_offs_q  <= mk_offs_q - GROUP_SPAN;
			mk_grp_q   <= mk_grp_q + GW'(1);
			mk_gaddr_q <= mk_gaddr_q + GROUP_STEP;
		end
	end

	// find issue counters
	always_ff @(posedge clk) begin
		if (start_find) begin
			iss_addr_q <= '0;
			iss_byte_q <= '0;
			iss_grp_q  <= '0;
			iss_base_q <= cfg.first_group_block;
		end else if ((state_q == bba_pkg::S_FIND) && !iss_done_q) begin
			iss_addr_q <= iss_addr_q + AW'(1);
			if (iss_byte_q == LAST_BYTE) begin
				iss_byte_q <= '0;
				iss_grp_q  <= iss_grp_q + GW'(1);
				iss_base_q <= iss_base_q + GROUP_SPAN;
			end else begin
				iss_byte_q <= iss_byte_q + BYW'(1);
			end
		end
	end

	// find control: scan end and check-stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_done_q   <= 1'b1;
			chk_v_s1     <= 1'b0;
			chk_final_s1 <= 1'b0;
		end else if (start_find) begin
			iss_done_q   <= 1'b0;
			chk_v_s1     <= 1'b0;
			chk_final_s1 <= 1'b0;
		end else if ((state_q == bba_pkg::S_FIND) && !iss_done_q) begin
			iss_done_q   <= iss_last;
			chk_v_s1     <= 1'b1;
			chk_final_s1 <= iss_last;
		end else begin
			chk_v_s1     <= 1'b0;
			chk_final_s1 <= 1'b0;
		end
	end

	// check-stage payload follows the read
	always_ff @(posedge clk) begin
		if (mem_re && (state_q == bba_pkg::S_FIND)) begin
			chk_byte_s1 <= iss_byte_q;
			chk_base_s1 <= iss_base_q;
			chk_tail_s1 <= iss_byte_q == LAST_BYTE;
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status_d;
			res_free_q   <= res_free_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_free_q   <= res_free_q;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.free_block = out_free_q;

	// checks
	`BBA_IMPLIES(a_we_phase, mem_we, (state_q == bba_pkg::S_CLEAR) || (state_q == bba_pkg::S_MK_MOD), "ram write outside clear or mark update")
	`BBA_IMPLIES(a_no_rw_overlap, mem_we, !mem_re, "ram read and write in the same cycle")
	`BBA_NEXT(a_accept_starts, req.valid && req.ready, state_q != bba_pkg::S_IDLE, "accepted request did not start work")
	`BBA_IMPLIES(a_fail_zero, rsp.valid && (rsp.status != bba_pkg::STAT_OK), rsp.free_block == 32'd0, "failed beat carries a nonzero block")

endmodule

`default_nettype wire
